### rtl/cruise_speed_spacing_law_assert.svh
// Assertion macros for the cruise spacing law block.
`ifndef CRUISE_SPEED_SPACING_LAW_ASSERT_SVH
`define CRUISE_SPEED_SPACING_LAW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csl_pkg.sv
// Shared types and constants for the cruise spacing law block.
package csl_pkg;

  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 35;
  localparam int SQRT_IN_W  = 32;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  // floor(2^24/18) and floor(2^24/5); quotient is exact after one correction
  localparam int                       RECIP_SHIFT = 24;
  localparam logic signed [MUL_W-1:0]  RECIP18     = 24'sd932067;
  localparam logic signed [MUL_W-1:0]  RECIP5      = 24'sd3355443;

  typedef enum logic [2:0] {
    IDX_SCAN_RATE,
    IDX_FILTER_COEFF,
    IDX_MAX_SPEED,
    IDX_MIN_GAP,
    IDX_HEADWAY_GAIN,
    IDX_DECEL_GAIN,
    IDX_CATCHUP_MARGIN,
    IDX_IDLE_SPEED
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_V,
    ST_V2,
    ST_RF,
    ST_CMP,
    ST_T,
    ST_SQ,
    ST_VD,
    ST_CL,
    ST_KMH,
    ST_OUT
  } seq_state_t;

endpackage

### rtl/csl_mul.sv
// Shared signed multiplier with registered product.
module csl_mul (
  input  logic                               clk,
  input  logic signed [csl_pkg::MUL_W-1:0]   a,
  input  logic signed [csl_pkg::MUL_W-1:0]   b,
  output logic signed [csl_pkg::PROD_W-1:0]  p
);
  import csl_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

### rtl/csl_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module csl_sqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [csl_pkg::SQRT_IN_W-1:0]       arg,
  output logic [csl_pkg::SQRT_OUT_W-1:0]      root,
  output logic                                done
);
  import csl_pkg::*;

  localparam int REM_W  = SQRT_OUT_W + 1;
  localparam int STEP_W = $clog2(SQRT_OUT_W);

  logic [SQRT_IN_W-1:0]  x_r;
  logic [REM_W-1:0]      rem_r;
  logic [SQRT_OUT_W-1:0] root_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic                  done_r;
  logic [REM_W+1:0]      rem_sh;
  logic [REM_W+1:0]      trial;
  logic                  fits;

  assign rem_sh = {rem_r, x_r[SQRT_IN_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == STEP_W'(SQRT_OUT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SQRT_OUT_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= arg;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= x_r << 2;
      rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[SQRT_OUT_W-2:0], fits};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### rtl/cruise_speed_spacing_law.sv
// Top level: cruise spacing law sequencer, datapath and register file.
// Sequence: MEAS, F1, F2, F3, then OUT without a track; with a track V, V2, RF,
//   CMP, VD, CL, KMH, OUT, with T and SQ (square root) on the braking-curve path.
// One item at a time: one shared 24x24 multiplier and the 16-step square root unit
//   serve all steps. Input is taken only in the idle state.
// Reset (synchronous, rst_n low): registers to their defaults, filter state to zero.
`include "cruise_speed_spacing_law_assert.svh"

module cruise_speed_spacing_law #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [47:0]                   in_tdata,   // own_speed, target_range, range_change
  input  logic [0:0]                    in_tuser,   // target_found
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // cruise_speed, rel_speed_filtered
  output logic [0:0]                    out_tuser,  // target_valid
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [csl_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [csl_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [csl_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import csl_pkg::*;

  // rfin = min_gap + round(v * headway_gain / 2^F) needs RF_W bits
  localparam int RF_W = 32 - FRAC_BITS;
  localparam int DF_W = RF_W + 2;   // gap difference / braking speed
  localparam int VD_W = RF_W + 3;   // desired speed before clamp

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(32767)) begin
      return 16'sh7FFF;
    end else if (x < -ACC_W'(32768)) begin
      return 16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic [7:0]  scan_rate_r;
  logic [15:0] filter_coeff_r;
  logic [15:0] max_speed_r;
  logic [14:0] min_gap_r;
  logic [15:0] headway_gain_r;
  logic [15:0] decel_gain_r;
  logic [15:0] catchup_margin_r;
  logic [15:0] idle_speed_r;
  logic        cfg_wr;
  cfg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_rate_r      <= 8'd25;
      filter_coeff_r   <= 16'd1285;
      max_speed_r      <= 16'd4352;
      min_gap_r        <= 15'd2048;
      headway_gain_r   <= 16'd128;
      decel_gain_r     <= 16'd1451;
      catchup_margin_r <= 16'd1280;
      idle_speed_r     <= 16'd6400;
    end else if (cfg_wr) begin
      case (cfg_idx)
        IDX_SCAN_RATE:      scan_rate_r      <= cfg_pwdata[7:0];
        IDX_FILTER_COEFF:   filter_coeff_r   <= cfg_pwdata[15:0];
        IDX_MAX_SPEED:      max_speed_r      <= cfg_pwdata[15:0];
        IDX_MIN_GAP:        min_gap_r        <= cfg_pwdata[14:0];
        IDX_HEADWAY_GAIN:   headway_gain_r   <= cfg_pwdata[15:0];
        IDX_DECEL_GAIN:     decel_gain_r     <= cfg_pwdata[15:0];
        IDX_CATCHUP_MARGIN: catchup_margin_r <= cfg_pwdata[15:0];
        IDX_IDLE_SPEED:     idle_speed_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      IDX_SCAN_RATE:      cfg_prdata = CFG_DW'(scan_rate_r);
      IDX_FILTER_COEFF:   cfg_prdata = CFG_DW'(filter_coeff_r);
      IDX_MAX_SPEED:      cfg_prdata = CFG_DW'(max_speed_r);
      IDX_MIN_GAP:        cfg_prdata = CFG_DW'(min_gap_r);
      IDX_HEADWAY_GAIN:   cfg_prdata = CFG_DW'(headway_gain_r);
      IDX_DECEL_GAIN:     cfg_prdata = CFG_DW'(decel_gain_r);
      IDX_CATCHUP_MARGIN: cfg_prdata = CFG_DW'(catchup_margin_r);
      IDX_IDLE_SPEED:     cfg_prdata = CFG_DW'(idle_speed_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  seq_state_t               state_r, state_nxt;
  logic signed [15:0]       fs_r, fs_nxt;          // filtered relative speed
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [31:0]              out_tdata_r, out_tdata_nxt;
  logic                     out_tuser_r, out_tuser_nxt;

  logic [15:0]              own_r, own_nxt;
  logic                     found_r, found_nxt;
  logic signed [15:0]       range_r, range_nxt;
  logic signed [15:0]       change_r, change_nxt;
  logic signed [15:0]       meas_r, meas_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [14:0]              v_r, v_nxt;            // own speed in m/s
  logic [RF_W-1:0]          rfin_r, rfin_nxt;      // gap target
  logic signed [DF_W-1:0]   rvd_r, rvd_nxt;        // gap-derived speed term
  logic signed [VD_W-1:0]   vd_r, vd_nxt;
  logic [20:0]              kx_r, kx_nxt;          // vdes * 18 + 2
  logic [15:0]              cruise_r, cruise_nxt;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     sq_start;
  logic [SQRT_IN_W-1:0]     sq_arg;
  logic [SQRT_OUT_W-1:0]    sq_root;
  logic                     sq_done;

  csl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  csl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .arg   (sq_arg),
    .root  (sq_root),
    .done  (sq_done)
  );

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [18:0]              own_x;      // own * 5 + 9
  logic [14:0]              q18;
  logic [18:0]              r18;
  logic [31:0]              rf_round;
  logic [RF_W-1:0]          rfin_calc;
  logic signed [DF_W-1:0]   diff;       // range - rfin
  logic                     range_lt_min;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [VD_W-1:0]   v_ext;
  logic signed [VD_W-1:0]   vmax_ext;
  logic signed [VD_W-1:0]   vd_raw;
  logic signed [VD_W-1:0]   catchup_lim;
  logic [15:0]              vdc;
  logic [20:0]              kx_calc;
  logic [17:0]              q5;
  logic [20:0]              r5;
  logic [17:0]              q5c;

  // km/h to m/s: (own*5 + 9) / 18 by reciprocal, one correction step
  assign own_x = {1'b0, own_r, 2'b00} + {3'b000, own_r} + 19'd9;
  assign q18   = mul_p[RECIP_SHIFT +: 15];
  assign r18   = own_x - ({q18, 4'b0000} + {3'b000, q18, 1'b0});

  assign rf_round  = mul_p[31:0] + (32'd1 << (FRAC_BITS - 1));
  assign rfin_calc = RF_W'(rf_round >> FRAC_BITS) + RF_W'(min_gap_r);

  assign diff         = DF_W'(range_r) - $signed({2'b00, rfin_r});
  assign range_lt_min = range_r < $signed({1'b0, min_gap_r});

  // braking curve argument: floor(t) * 2^F with low fraction bits dropped
  assign sq_arg = {1'b0, mul_p[30:FRAC_BITS], {FRAC_BITS{1'b0}}};

  assign acc_sum = acc_r + $signed(mul_p[ACC_W-1:0]);

  assign v_ext       = VD_W'($signed({1'b0, v_r}));
  assign vmax_ext    = VD_W'($signed({1'b0, max_speed_r}));
  assign vd_raw      = v_ext + VD_W'(fs_r) - VD_W'(rvd_r);
  assign catchup_lim = v_ext + VD_W'($signed({1'b0, catchup_margin_r}));

  // clamp to [0, max_speed]; zero range with a track forces full speed
  always_comb begin
    if (range_r == 16'sd0) begin
      vdc = max_speed_r;
    end else if (vd_r < 0) begin
      vdc = 16'd0;
    end else if (vd_r > vmax_ext) begin
      vdc = max_speed_r;
    end else begin
      vdc = vd_r[15:0];
    end
  end

  // m/s to km/h: (vdes*18 + 2) / 5 by reciprocal, one correction step
  assign kx_calc = {1'b0, vdc, 4'b0000} + {4'b0000, vdc, 1'b0} + 21'd2;
  assign q5      = mul_p[RECIP_SHIFT +: 18];
  assign r5      = kx_r - ({1'b0, q5, 2'b00} + {3'b000, q5});
  assign q5c     = q5 + 18'(r5 >= 21'd5);

  // ---------------------------------------------------------------------------
  // Sequencer: each multiply is issued in one state and used in the next
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    fs_nxt         = fs_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    own_nxt        = own_r;
    found_nxt      = found_r;
    range_nxt      = range_r;
    change_nxt     = change_r;
    meas_nxt       = meas_r;
    acc_nxt        = acc_r;
    v_nxt          = v_r;
    rfin_nxt       = rfin_r;
    rvd_nxt        = rvd_r;
    vd_nxt         = vd_r;
    kx_nxt         = kx_r;
    cruise_nxt     = cruise_r;
    mul_a          = '0;
    mul_b          = '0;
    sq_start       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          own_nxt    = in_tdata[15:0];
          range_nxt  = in_tdata[31:16];
          change_nxt = in_tdata[47:32];
          found_nxt  = in_tuser[0];
          state_nxt  = ST_MEAS;
        end
      end
      ST_MEAS: begin
        // relative speed from range change times scan rate
        mul_a     = MUL_W'(change_r);
        mul_b     = $signed(MUL_W'(scan_rate_r));
        state_nxt = ST_F1;
      end
      ST_F1: begin
        meas_nxt  = found_r ? sat16($signed(mul_p[ACC_W-1:0])) : 16'sd0;
        mul_a     = $signed(MUL_W'(17'h10000 - {1'b0, filter_coeff_r}));
        mul_b     = MUL_W'(fs_r);
        state_nxt = ST_F2;
      end
      ST_F2: begin
        acc_nxt   = $signed(mul_p[ACC_W-1:0]) + ACC_W'(32768);
        mul_a     = $signed(MUL_W'(filter_coeff_r));
        mul_b     = MUL_W'(meas_r);
        state_nxt = ST_F3;
      end
      ST_F3: begin
        fs_nxt = sat16(acc_sum >>> 16);
        mul_a  = $signed(MUL_W'(own_x));
        mul_b  = RECIP18;
        if (found_r) begin
          state_nxt = ST_V;
        end else begin
          cruise_nxt = idle_speed_r;
          state_nxt  = ST_OUT;
        end
      end
      ST_V: begin
        v_nxt     = q18 + 15'(r18 >= 19'd18);
        state_nxt = ST_V2;
      end
      ST_V2: begin
        mul_a     = $signed(MUL_W'(v_r));
        mul_b     = $signed(MUL_W'(headway_gain_r));
        state_nxt = ST_RF;
      end
      ST_RF: begin
        rfin_nxt  = rfin_calc;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (range_lt_min) begin
          // inside minimum gap: back off by the gap error
          rvd_nxt   = -diff;
          state_nxt = ST_VD;
        end else if (diff > 0) begin
          // diff is below 2^15 here
          mul_a     = $signed(MUL_W'(diff[14:0]));
          mul_b     = $signed(MUL_W'(decel_gain_r));
          state_nxt = ST_T;
        end else begin
          rvd_nxt   = '0;
          state_nxt = ST_VD;
        end
      end
      ST_T: begin
        sq_start  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (sq_done) begin
          rvd_nxt   = -DF_W'($signed({1'b0, sq_root}));
          state_nxt = ST_VD;
        end
      end
      ST_VD: begin
        // far behind the computed speed: catch up at full speed
        vd_nxt    = (catchup_lim < vd_raw) ? vmax_ext : vd_raw;
        state_nxt = ST_CL;
      end
      ST_CL: begin
        kx_nxt    = kx_calc;
        mul_a     = $signed(MUL_W'(kx_calc));
        mul_b     = RECIP5;
        state_nxt = ST_KMH;
      end
      ST_KMH: begin
        cruise_nxt = (q5c > 18'd65535) ? 16'hFFFF : q5c[15:0];
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        // output register frees up when the held result transfers
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {fs_r, cruise_r};
          out_tuser_nxt  = found_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fs_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fs_r         <= fs_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    own_r       <= own_nxt;
    found_r     <= found_nxt;
    range_r     <= range_nxt;
    change_r    <= change_nxt;
    meas_r      <= meas_nxt;
    acc_r       <= acc_nxt;
    v_r         <= v_nxt;
    rfin_r      <= rfin_nxt;
    rvd_r       <= rvd_nxt;
    vd_r        <= vd_nxt;
    kx_r        <= kx_nxt;
    cruise_r    <= cruise_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CSL_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "input taken while busy")
  `CSL_ASSERT_SAME(a_idle_when_no_track, out_tvalid && !out_tuser[0], out_tdata[15:0] == idle_speed_r, "no-track result is not idle speed")
  `CSL_ASSERT_SAME(a_zero_ceiling, out_tvalid && out_tuser[0] && max_speed_r == 16'd0, out_tdata[15:0] == 16'd0, "result above zero ceiling")
  `CSL_ASSERT_SAME(a_sqrt_done_in_wait, sq_done, state_r == ST_SQ, "square root finished outside its wait state")

endmodule
